/* rtl/csf_pkg.sv */
package csf_pkg;

  // channel code width
  localparam int PIX_W = 8;
  // one RGB pixel as stored in the line memories
  localparam int RGB_W = 3 * PIX_W;

  // configuration register widths and write port
  localparam int FW_W  = 11;
  localparam int FH_W  = 13;
  localparam int CFG_W = 13;
  localparam int IDX_W = 1;

  // register indexes
  localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  // register reset values
  localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 11'd1024;
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 13'd1024;

  // tallest frame and row counter width
  localparam logic [FH_W-1:0] HEIGHT_MAX = 13'd4096;
  localparam int ROW_W = 12;

  // longest line held in the line memories
  localparam int MAX_LINE_DEFAULT = 1024;

  // input item kinds
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_DRAIN = 1'b1;

endpackage

/* rtl/cross_sharpen_filter_core.sv */
// A pixel-yielding item passes the window stage and the output register before out_valid.
// Throughput: one item per cycle with in_stall low; the line memories take one write and
// two reads per beat. Row 0 pixels and out-of-phase items are consumed without a result.
// Reset (rst, synchronous): counters, drain flag and valid bits clear, registers take
// their reset values; line memories are not cleared, so there is no start-up pass.
module cross_sharpen_filter_core #(
  parameter int MAX_LINE = csf_pkg::MAX_LINE_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  // configuration
  input  logic                      cfg_write,
  input  logic [csf_pkg::IDX_W-1:0] cfg_index,
  input  logic [csf_pkg::CFG_W-1:0] cfg_data,
  // input channel
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      kind,
  input  logic [csf_pkg::PIX_W-1:0] red_in,
  input  logic [csf_pkg::PIX_W-1:0] green_in,
  input  logic [csf_pkg::PIX_W-1:0] blue_in,
  // output channel
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [csf_pkg::PIX_W-1:0] red_out,
  output logic [csf_pkg::PIX_W-1:0] green_out,
  output logic [csf_pkg::PIX_W-1:0] blue_out,
  output logic                      frame_last
);

  localparam int COL_W = (MAX_LINE > 1) ? $clog2(MAX_LINE) : 1;
  localparam int EW    = $clog2(MAX_LINE + 1);
  localparam int PW    = csf_pkg::PIX_W;
  localparam int RW    = csf_pkg::RGB_W;

  // configuration registers
  logic [csf_pkg::FW_W-1:0] frame_width;
  logic [csf_pkg::FH_W-1:0] frame_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= csf_pkg::FRAME_WIDTH_RST;
      frame_height <= csf_pkg::FRAME_HEIGHT_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        csf_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data[csf_pkg::FW_W-1:0];
        csf_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data[csf_pkg::FH_W-1:0];
        default: ;
      endcase
    end
  end

  // effective frame size
  logic [EW-1:0]            eff_w;
  logic [csf_pkg::FH_W-1:0] eff_h;

  always_comb begin
    if (frame_width == '0) begin
      eff_w = EW'(1);
    end else if (32'(frame_width) > MAX_LINE) begin
      eff_w = EW'(MAX_LINE);
    end else begin
      eff_w = EW'(frame_width);
    end
    if (frame_height == '0) begin
      eff_h = csf_pkg::FH_W'(1);
    end else if (frame_height > csf_pkg::HEIGHT_MAX) begin
      eff_h = csf_pkg::HEIGHT_MAX;
    end else begin
      eff_h = frame_height;
    end
  end

  // raster position
  logic [COL_W-1:0]         column_count;
  logic [csf_pkg::ROW_W-1:0] row_count;
  logic [COL_W-1:0]         drained_count;
  logic                     draining;

  logic                     accept;
  logic                     active;
  logic                     produce;
  logic [COL_W-1:0]         cur_c;
  logic [EW-1:0]            c_inc;
  logic                     c_last;
  logic [COL_W-1:0]         right_c;
  logic [csf_pkg::FH_W-1:0] row_inc;
  logic                     row_done;
  logic                     pix_write;
  logic [RW-1:0]            pix;

  always_comb begin
    active    = (kind == csf_pkg::KIND_DRAIN) ? draining : !draining;
    cur_c     = draining ? drained_count : column_count;
    c_inc     = EW'(cur_c) + EW'(1);
    c_last    = (c_inc >= eff_w);
    right_c   = c_last ? cur_c : c_inc[COL_W-1:0];
    row_inc   = {1'b0, row_count} + csf_pkg::FH_W'(1);
    row_done  = (row_inc >= eff_h);
    produce   = active && ((kind == csf_pkg::KIND_DRAIN) || (row_count != '0));
    pix_write = accept && active && (kind == csf_pkg::KIND_PIXEL);
    pix       = {red_in, green_in, blue_in};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count  <= '0;
      row_count     <= '0;
      drained_count <= '0;
      draining      <= 1'b0;
    end else if (accept && active) begin
      if (kind == csf_pkg::KIND_DRAIN) begin
        if (c_last) begin
          draining      <= 1'b0;
          drained_count <= '0;
          row_count     <= '0;
          column_count  <= '0;
        end else begin
          drained_count <= c_inc[COL_W-1:0];
        end
      end else begin
        if (c_last) begin
          column_count <= '0;
          if (row_done) begin
            draining      <= 1'b1;
            drained_count <= '0;
          end else begin
            row_count <= row_inc[csf_pkg::ROW_W-1:0];
          end
        end else begin
          column_count <= c_inc[COL_W-1:0];
        end
      end
    end
  end

  // line memories, one per row parity; port a reads the column, port b its right neighbor
  logic [RW-1:0] m0_a, m0_b, m1_a, m1_b;

  csf_line_mem #(.DEPTH(MAX_LINE), .AW(COL_W), .DW(RW)) u_line0 (
    .clk     (clk),
    .we      (pix_write && !row_count[0]),
    .waddr   (cur_c),
    .wdata   (pix),
    .re      (accept),
    .raddr_a (cur_c),
    .raddr_b (right_c),
    .rdata_a (m0_a),
    .rdata_b (m0_b)
  );

  csf_line_mem #(.DEPTH(MAX_LINE), .AW(COL_W), .DW(RW)) u_line1 (
    .clk     (clk),
    .we      (pix_write && row_count[0]),
    .waddr   (cur_c),
    .wdata   (pix),
    .re      (accept),
    .raddr_a (cur_c),
    .raddr_b (right_c),
    .rdata_a (m1_a),
    .rdata_b (m1_b)
  );

  // window stage: flags travel alongside the memory reads
  typedef struct packed {
    logic last;
    logic left_self;
    logic up_self;
    logic down_self;
    logic ctr_par;
  } s1_ctl_t;

  logic          s1_valid;
  s1_ctl_t       s1_ctl;
  logic [RW-1:0] s1_down;
  logic [RW-1:0] left_pix;
  logic          out_load;

  always_comb begin
    out_load = s1_valid && (!out_valid || !out_stall);
    in_stall = s1_valid && !out_load;
    accept   = in_valid && !in_stall;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= accept && produce;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_down <= pix;
      if (kind == csf_pkg::KIND_DRAIN) begin
        s1_ctl.last      <= c_last;
        s1_ctl.up_self   <= (row_count == '0);
        s1_ctl.down_self <= 1'b1;
        s1_ctl.ctr_par   <= row_count[0];
      end else begin
        s1_ctl.last      <= 1'b0;
        s1_ctl.up_self   <= (row_count == csf_pkg::ROW_W'(1));
        s1_ctl.down_self <= 1'b0;
        s1_ctl.ctr_par   <= !row_count[0];
      end
      s1_ctl.left_self <= (cur_c == '0);
    end
  end

  // neighbor selection
  logic [RW-1:0] w_center, w_up, w_down, w_left, w_right;

  always_comb begin
    w_center = s1_ctl.ctr_par ? m1_a : m0_a;
    w_right  = s1_ctl.ctr_par ? m1_b : m0_b;
    w_up     = s1_ctl.up_self ? w_center : (s1_ctl.ctr_par ? m0_a : m1_a);
    w_down   = s1_ctl.down_self ? w_center : s1_down;
    w_left   = s1_ctl.left_self ? w_center : left_pix;
  end

  // the center of one beat is the left neighbor of the next
  always_ff @(posedge clk) begin
    if (out_load) begin
      left_pix <= w_center;
    end
  end

  // one lane per channel
  logic [PW-1:0] lane_res [0:2];

  for (genvar g = 0; g < 3; g++) begin : g_lane
    localparam int LO = (2 - g) * PW;
    csf_lane u_lane (
      .center (w_center[LO +: PW]),
      .up     (w_up[LO +: PW]),
      .down   (w_down[LO +: PW]),
      .left   (w_left[LO +: PW]),
      .right  (w_right[LO +: PW]),
      .result (lane_res[g])
    );
  end

  // merge lanes into the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      red_out    <= lane_res[0];
      green_out  <= lane_res[1];
      blue_out   <= lane_res[2];
      frame_last <= s1_ctl.last;
    end
  end

endmodule

/* rtl/csf_line_mem.sv */
module csf_line_mem #(
  parameter int DEPTH = csf_pkg::MAX_LINE_DEFAULT,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  parameter int DW    = csf_pkg::RGB_W
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr_a,
  input  logic [AW-1:0] raddr_b,
  output logic [DW-1:0] rdata_a,
  output logic [DW-1:0] rdata_b
);

  logic [DW-1:0] mem [0:DEPTH-1];

  // one write, two registered reads; a read at the write address returns old data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

/* rtl/csf_lane.sv */
module csf_lane (
  input  logic [csf_pkg::PIX_W-1:0] center,
  input  logic [csf_pkg::PIX_W-1:0] up,
  input  logic [csf_pkg::PIX_W-1:0] down,
  input  logic [csf_pkg::PIX_W-1:0] left,
  input  logic [csf_pkg::PIX_W-1:0] right,
  output logic [csf_pkg::PIX_W-1:0] result
);

  localparam int SW = csf_pkg::PIX_W + 4;

  logic [SW-1:0]        five_c;
  logic [SW-1:0]        nsum;
  logic signed [SW-1:0] diff;

  // 5*center - neighbors, clamped to one channel code
  always_comb begin
    five_c = {2'b00, center, 2'b00} + {4'b0000, center};
    nsum   = SW'(up) + SW'(down) + SW'(left) + SW'(right);
    diff   = signed'(five_c - nsum);
    if (diff < 0) begin
      result = '0;
    end else if (diff > signed'(SW'({csf_pkg::PIX_W{1'b1}}))) begin
      result = '1;
    end else begin
      result = diff[csf_pkg::PIX_W-1:0];
    end
  end

endmodule
